// ===== rtl/core/tfst_pkg.sv =====
// Shared definitions for the TCP flow state tracker: table geometry, TCP flag
// masks, flow state codes and the status structs passed between the modules.
// Has no dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package tfst_pkg;

  // Table geometry.
  localparam int FLOW_ENTRIES = 64;
  localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int KEY_W        = 256;  // four 64-bit address words
  localparam int PORTS_W      = 32;   // src_port in [15:0], dst_port in [31:16]

  // TCP flag byte masks.
  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_RST = 8'h04;
  localparam logic [7:0] FL_ACK = 8'h10;

  // Flow states.
  localparam logic [1:0] ST_SYN_SENT    = 2'd0;
  localparam logic [1:0] ST_ESTABLISHED = 2'd1;
  localparam logic [1:0] ST_CLOSING     = 2'd2;

  // Outcome of one sweep of the key table.
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } scan_stat_t;

  // Request to the per-entry state table.
  typedef struct packed {
    logic             upd;    // read-modify-write of a matched entry
    logic             ins;    // write a fresh SYN_SENT entry
    logic [IDX_W-1:0] idx;
    logic [7:0]       flags;
    logic [63:0]      now;
  } ent_req_t;

  // Answer of the per-entry state table after an update.
  typedef struct packed {
    logic        valid;
    logic [1:0]  state;
    logic [31:0] count;
  } ent_resp_t;

endpackage

// ===== rtl/core/tfst_match_scan.sv =====
// Key table of the flow tracker with its valid bits and the sequential
// match sweep that finds the hit entry and the lowest free slot.
// Depends on tfst_pkg.
`timescale 1ns / 1ps

module tfst_match_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tfst_pkg::KEY_W-1:0]    key,
  input  logic [tfst_pkg::PORTS_W-1:0]  ports,
  input  logic                          is_v6,
  input  logic                          ins_we,
  input  logic [tfst_pkg::IDX_W-1:0]    ins_idx,
  output tfst_pkg::scan_stat_t          stat
);

  localparam int ENT_W = tfst_pkg::KEY_W + tfst_pkg::PORTS_W + 1;
  localparam int CMP_W = tfst_pkg::KEY_W + tfst_pkg::PORTS_W;

  logic [ENT_W-1:0]                 mem [tfst_pkg::FLOW_ENTRIES];
  logic [ENT_W-1:0]                 rd_data_r;
  logic [tfst_pkg::FLOW_ENTRIES-1:0] valid_r;
  logic [tfst_pkg::IDX_W-1:0]       cnt_r;
  logic                             issue_r;
  logic                             cmp_r;
  logic                             cmp_last_r;
  logic                             cmp_valid_r;
  logic [tfst_pkg::IDX_W-1:0]       cmp_idx_r;
  logic                             hit_r;
  logic [tfst_pkg::IDX_W-1:0]       hit_idx_r;
  logic                             free_r;
  logic [tfst_pkg::IDX_W-1:0]       free_idx_r;
  logic                             done_r;
  logic                             issue_last;
  logic                             match;

  assign issue_last = (cnt_r == tfst_pkg::IDX_W'(tfst_pkg::FLOW_ENTRIES - 1));
  // The recorded IPv6 bit is not part of the match.
  assign match      = (rd_data_r[CMP_W-1:0] == {ports, key});

  // Storage: one entry written on insert, one entry read per sweep cycle.
  always_ff @(posedge clk) begin
    if (ins_we) begin
      mem[ins_idx] <= {is_v6, ports, key};
    end
    rd_data_r <= mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      cmp_r       <= 1'b0;
      cmp_last_r  <= 1'b0;
      cmp_valid_r <= 1'b0;
      cmp_idx_r   <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      free_r      <= 1'b0;
      free_idx_r  <= '0;
      done_r      <= 1'b0;
    end else begin
      done_r      <= cmp_r && cmp_last_r;
      cmp_r       <= issue_r;
      cmp_last_r  <= issue_r && issue_last;
      cmp_valid_r <= valid_r[cnt_r];
      cmp_idx_r   <= cnt_r;
      if (start) begin
        issue_r <= 1'b1;
        cnt_r   <= '0;
        hit_r   <= 1'b0;
        free_r  <= 1'b0;
      end else begin
        if (issue_r) begin
          cnt_r <= cnt_r + tfst_pkg::IDX_W'(1);
          if (issue_last) begin
            issue_r <= 1'b0;
          end
          if (!valid_r[cnt_r] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= cnt_r;
          end
        end
        if (cmp_r && cmp_valid_r && match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
      end
      if (ins_we) begin
        valid_r[ins_idx] <= 1'b1;
      end
    end
  end

  assign stat.done     = done_r;
  assign stat.hit      = hit_r;
  assign stat.hit_idx  = hit_idx_r;
  assign stat.free     = free_r;
  assign stat.free_idx = free_idx_r;

endmodule

// ===== rtl/core/tfst_entry_update.sv =====
// Per-entry flow state table (state, packet count, last-seen time) with the
// read-modify-write update applied on a matched packet.
// Depends on tfst_pkg.
`timescale 1ns / 1ps

module tfst_entry_update (
  input  logic                clk,
  input  logic                rst_n,
  input  tfst_pkg::ent_req_t  req,
  output tfst_pkg::ent_resp_t resp
);

  localparam int DATA_W = 64 + 32 + 2;

  logic [DATA_W-1:0]          mem [tfst_pkg::FLOW_ENTRIES];
  logic [DATA_W-1:0]          rd_data_r;
  logic                       pend_r;
  logic [tfst_pkg::IDX_W-1:0] pend_idx_r;
  logic [7:0]                 flags_r;
  logic [63:0]                now_r;
  logic                       resp_valid_r;
  logic [1:0]                 resp_state_r;
  logic [31:0]                resp_count_r;
  logic [1:0]                 st_old;
  logic [1:0]                 st_nxt;
  logic [31:0]                cnt_nxt;

  assign st_old  = rd_data_r[1:0];
  assign cnt_nxt = rd_data_r[33:2] + 32'd1;

  // ACK completes the handshake; FIN or RST closes from any state.
  always_comb begin
    st_nxt = st_old;
    if ((st_old == tfst_pkg::ST_SYN_SENT) && ((flags_r & tfst_pkg::FL_ACK) != 8'd0)) begin
      st_nxt = tfst_pkg::ST_ESTABLISHED;
    end
    if ((flags_r & (tfst_pkg::FL_RST | tfst_pkg::FL_FIN)) != 8'd0) begin
      st_nxt = tfst_pkg::ST_CLOSING;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ins) begin
      mem[req.idx] <= {req.now, 32'd1, tfst_pkg::ST_SYN_SENT};
    end else if (pend_r) begin
      mem[pend_idx_r] <= {now_r, cnt_nxt, st_nxt};
    end
    rd_data_r <= mem[req.idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= 1'b0;
      resp_valid_r <= 1'b0;
    end else begin
      pend_r       <= req.upd;
      resp_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.upd) begin
      pend_idx_r <= req.idx;
      flags_r    <= req.flags;
      now_r      <= req.now;
    end
    if (pend_r) begin
      resp_state_r <= st_nxt;
      resp_count_r <= cnt_nxt;
    end
  end

  assign resp.valid = resp_valid_r;
  assign resp.state = resp_state_r;
  assign resp.count = resp_count_r;

endmodule

// ===== rtl/core/tcp_flow_state_tracker_unit.sv =====
// The key sweep reads one table entry per cycle through the single read port of the
// key table. The block takes one packet at a time: a new input beat is accepted only
// once the result of the last packet has been loaded into the output register.
// Reset (rst_n low, synchronous) clears all valid bits and control state; the tables
// need no clearing pass, so the block accepts a beat in the first cycle after reset.
`timescale 1ns / 1ps

module tcp_flow_state_tracker_unit (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata from bit 0: src_addr_hi[63:0], src_addr_lo[127:64], dst_addr_hi[191:128],
  // dst_addr_lo[255:192], src_port[271:256], dst_port[287:272], flag_byte[295:288],
  // current_time[359:296].
  input  logic [359:0] in_tdata,
  // tuser: is_v6[0].
  input  logic         in_tuser,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata from bit 0: allow[0], new_flow[1], established_hit[2], flow_state[4:3],
  // packet_count[36:5], table_full[37], zero fill [39:38].
  output logic [39:0]  out_tdata
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an input beat
  localparam logic [1:0] S_SCAN = 2'd1;  // sweeping the key table
  localparam logic [1:0] S_UPD  = 2'd2;  // read-modify-write of a matched entry
  localparam logic [1:0] S_EMIT = 2'd3;  // handing the result to the output register

  logic [1:0]                   state_r;
  logic [1:0]                   state_nxt;
  logic [tfst_pkg::KEY_W-1:0]   key_r;
  logic [tfst_pkg::PORTS_W-1:0] ports_r;
  logic                         v6_r;
  logic [7:0]                   flags_r;
  logic [63:0]                  now_r;
  logic                         res_allow_r;
  logic                         res_new_r;
  logic                         res_est_r;
  logic [1:0]                   res_state_r;
  logic [31:0]                  res_count_r;
  logic                         res_full_r;
  logic                         out_valid_r;
  logic [39:0]                  out_data_r;
  logic                         in_fire;
  logic                         syn_only;
  logic                         out_load;
  logic [tfst_pkg::KEY_W-1:0]   key_in;
  tfst_pkg::scan_stat_t         scan_stat;
  tfst_pkg::ent_req_t           ent_req;
  tfst_pkg::ent_resp_t          ent_resp;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // IPv4 keys keep only the low 32-bit word of each address; the other words are
  // cleared so that the key compares as a plain 256-bit value.
  always_comb begin
    if (in_tuser) begin
      key_in = in_tdata[255:0];
    end else begin
      key_in = {64'd0, 32'd0, in_tdata[159:128], 64'd0, 32'd0, in_tdata[31:0]};
    end
  end

  // Only a bare SYN (SYN set, ACK clear) may open a flow.
  assign syn_only = ((flags_r & (tfst_pkg::FL_SYN | tfst_pkg::FL_ACK)) == tfst_pkg::FL_SYN);

  // After the sweep a hit goes to the entry table for its update; a miss that
  // opens a flow writes both tables at the lowest free slot in the same cycle.
  always_comb begin
    ent_req.upd   = (state_r == S_SCAN) && scan_stat.done && scan_stat.hit;
    ent_req.ins   = (state_r == S_SCAN) && scan_stat.done && !scan_stat.hit &&
                    syn_only && scan_stat.free;
    ent_req.idx   = scan_stat.hit ? scan_stat.hit_idx : scan_stat.free_idx;
    ent_req.flags = flags_r;
    ent_req.now   = now_r;
  end

  // The output register may load when it is empty or being drained this cycle.
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_nxt = scan_stat.hit ? S_UPD : S_EMIT;
        end
      end
      S_UPD: begin
        if (ent_resp.valid) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Packet fields are held for the whole life of the packet in the block.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r   <= key_in;
      ports_r <= in_tdata[287:256];
      v6_r    <= in_tuser;
      flags_r <= in_tdata[295:288];
      now_r   <= in_tdata[359:296];
    end
  end

  // Result assembly. A dropped packet reports all zeros; a full table still lets
  // the SYN through but flags that no entry was made.
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && scan_stat.done && !scan_stat.hit) begin
      res_est_r <= 1'b0;
      if (!syn_only) begin
        res_allow_r <= 1'b0;
        res_new_r   <= 1'b0;
        res_state_r <= tfst_pkg::ST_SYN_SENT;
        res_count_r <= 32'd0;
        res_full_r  <= 1'b0;
      end else if (scan_stat.free) begin
        res_allow_r <= 1'b1;
        res_new_r   <= 1'b1;
        res_state_r <= tfst_pkg::ST_SYN_SENT;
        res_count_r <= 32'd1;
        res_full_r  <= 1'b0;
      end else begin
        res_allow_r <= 1'b1;
        res_new_r   <= 1'b0;
        res_state_r <= tfst_pkg::ST_SYN_SENT;
        res_count_r <= 32'd0;
        res_full_r  <= 1'b1;
      end
    end else if ((state_r == S_UPD) && ent_resp.valid) begin
      res_allow_r <= 1'b1;
      res_new_r   <= 1'b0;
      res_est_r   <= (ent_resp.state == tfst_pkg::ST_ESTABLISHED);
      res_state_r <= ent_resp.state;
      res_count_r <= ent_resp.count;
      res_full_r  <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= {2'b00, res_full_r, res_count_r, res_state_r,
                     res_est_r, res_new_r, res_allow_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The sweep starts on the accepting edge, when the key registers load.
  tfst_match_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire),
    .key     (key_r),
    .ports   (ports_r),
    .is_v6   (v6_r),
    .ins_we  (ent_req.ins),
    .ins_idx (ent_req.idx),
    .stat    (scan_stat)
  );

  tfst_entry_update u_entry (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ent_req),
    .resp  (ent_resp)
  );

  // A new flow is only made from an admitted packet with room in the table.
  a_new_flow_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_new_r |-> res_allow_r && !res_full_r)
    else $error("new flow reported without allow or with table full");

  // Inserts and updates never happen together and only right after a sweep.
  a_ins_upd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    ent_req.ins || ent_req.upd |-> !(ent_req.ins && ent_req.upd) && scan_stat.done)
    else $error("insert and update requested together or outside sweep end");

  // The entry table answers only to an earlier update, registered as pending and then as the response.
  a_resp_follows_upd: assert property (@(posedge clk) disable iff (!rst_n)
    ent_resp.valid |-> $past(ent_req.upd, 2) && (state_r == S_UPD))
    else $error("entry response without a matching update");

  // A sweep only ends while the sequencer waits for it.
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stat.done |-> (state_r == S_SCAN))
    else $error("key sweep finished outside the scan state");

endmodule
